[hw/rtl/assert_macros.svh]
// assertion macros shared by the rtl files
// no dependencies; every macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SSDP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssdp assertion failed");

// next-cycle implication
`define SSDP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssdp assertion failed");

`endif

[hw/rtl/ssdp_pkg.sv]
// constants and shared types of the subset-sum block
// no dependencies
package ssdp_pkg;

  localparam int VAL_W      = 12;
  localparam int MAX_ITEMS  = 32;
  localparam int MAX_TARGET = 4095;
  localparam int NWORDS     = (MAX_TARGET / 64) + 1;
  localparam int WORD_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int ROW_W      = $clog2(MAX_ITEMS + 1);
  localparam int CNT_W      = ROW_W;
  localparam int IDX_W      = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int RAM_DEPTH  = (MAX_ITEMS + 1) * (2 ** WORD_W);

  typedef logic [63:0] word_t;

  // read request to the reach table, two ports on the same cycle
  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row_a;
    logic [WORD_W-1:0] word_a;
    logic [ROW_W-1:0]  row_b;
    logic [WORD_W-1:0] word_b;
  } reach_rd_t;

  typedef struct packed {
    logic              en;
    logic [ROW_W-1:0]  row;
    logic [WORD_W-1:0] word;
    word_t             data;
  } reach_wr_t;

endpackage

[hw/rtl/ssdp_in_if.sv]
// input channel: one number of the set per item
// depends on ssdp_pkg
interface ssdp_in_if;
  import ssdp_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] item_value;
  logic             is_last;

  modport source (output valid, output item_value, output is_last, input ready);
  modport sink   (input valid, input item_value, input is_last, output ready);
endinterface

[hw/rtl/ssdp_out_if.sv]
// result channel: one chosen member or a final status per item
// depends on ssdp_pkg
interface ssdp_out_if;
  import ssdp_pkg::*;

  logic             valid;
  logic             ready;
  logic             found;
  logic             has_value;
  logic [VAL_W-1:0] chosen_value;
  logic             last_result;
  logic             overflow;

  modport source (output valid, output found, output has_value, output chosen_value,
                  output last_result, output overflow, input ready);
  modport sink   (input valid, input found, input has_value, input chosen_value,
                  input last_result, input overflow, output ready);
endinterface

[hw/rtl/subset_sum_dp_traceback_top.sv]
// subset-sum block: loads a set, builds the reachable-sum table, walks it back
// depends on ssdp_pkg, ssdp_in_if, ssdp_out_if, ssdp_reach_ram, assert_macros.svh
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      item_value[11:0], is_last
//  out_ch    out  valid/ready      found, has_value, chosen_value[11:0],
//                                  last_result, overflow
//  cfg_*     in   cfg_wr_en        cfg_wr_data[11:0] -> target_sum
//
// a non-final item is stored; the final item starts the build, row by row
// through fetch, row and drain states, set by the single 64-bit shift/or
// unit writing one table word a cycle, then a target check and a traceback
// of fetch, look, decrement and next steps per stored item, plus output stalls
// rst_n is synchronous; no clearing pass, rows 1 to n of the table are rebuilt per set
// in_ch.ready is low from the final item until the last result is registered
module subset_sum_dp_traceback_top (
  input  logic                     clk,
  input  logic                     rst_n,
  ssdp_in_if.sink                  in_ch,
  ssdp_out_if.source               out_ch,
  input  logic                     cfg_wr_en,
  input  logic [ssdp_pkg::VAL_W-1:0] cfg_wr_data
);
  import ssdp_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_ROW, S_DRAIN, S_CHK, S_CHK2,
    S_TFETCH, S_TLOOK, S_TDEC, S_TNEXT, S_FIN
  } state_t;

  state_t            state_r;
  logic [CNT_W-1:0]  count_r;
  logic              ovf_seen_r;
  logic [CNT_W-1:0]  n_r;
  logic              ovf_r;
  logic [VAL_W-1:0]  target_r;
  logic [VAL_W-1:0]  j_r;
  logic [VAL_W-1:0]  diff_r;
  logic [CNT_W-1:0]  row_r;
  logic [WORD_W-1:0] w_r;
  logic [VAL_W-1:0]  item_q_r;
  word_t             last_b_r;
  logic              wr_pend_r;
  logic [WORD_W-1:0] wr_w_r;
  logic              bval_r;
  logic              pend_valid_r;
  logic [VAL_W-1:0]  pend_val_r;
  logic              fin_found_r;

  logic              out_valid_r;
  logic              out_found_r;
  logic              out_has_r;
  logic [VAL_W-1:0]  out_val_r;
  logic              out_last_r;
  logic              out_ovf_r;

  // item store, read one entry per row or traceback step
  logic [VAL_W-1:0]  item_store [MAX_ITEMS];

  logic              in_fire;
  logic              slot_free;
  logic [CNT_W-1:0]  row_m1;
  logic              store_rd_en;
  logic              ws_ok;
  logic [WORD_W-1:0] s_word;
  logic [VAL_W-1:0]  diff;
  logic [5:0]        bs;
  word_t             b_eff;
  logic [127:0]      funnel;
  word_t             rd_data_a;
  word_t             rd_data_b;
  reach_rd_t         rd_req;
  reach_wr_t         wr_req;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;
  assign row_m1    = row_r - CNT_W'(1);
  assign diff      = j_r - item_q_r;
  assign bs        = item_q_r[5:0];

  // source word of the shifted row and whether it exists
  assign ws_ok  = 32'(w_r) >= 32'(item_q_r[VAL_W-1:6]);
  assign s_word = WORD_W'(32'(w_r) - 32'(item_q_r[VAL_W-1:6]));

  assign store_rd_en = (state_r == S_FETCH) || (state_r == S_TFETCH);

  always_ff @(posedge clk) begin
    if (in_fire && (32'(count_r) < MAX_ITEMS)) begin
      item_store[count_r[IDX_W-1:0]] <= in_ch.item_value;
    end
    if (store_rd_en) begin
      item_q_r <= item_store[row_m1[IDX_W-1:0]];
    end
  end

  // table read requests per phase
  always_comb begin
    rd_req        = '0;
    rd_req.row_a  = ROW_W'(row_m1);
    rd_req.word_a = w_r;
    rd_req.row_b  = ROW_W'(row_m1);
    rd_req.word_b = ws_ok ? s_word : w_r;
    unique case (state_r)
      S_ROW: begin
        rd_req.en = 1'b1;
      end
      S_CHK: begin
        rd_req.en     = 1'b1;
        rd_req.row_a  = ROW_W'(n_r);
        rd_req.word_a = WORD_W'(j_r >> 6);
      end
      S_TLOOK: begin
        rd_req.en     = (item_q_r <= j_r);
        rd_req.word_a = WORD_W'(diff >> 6);
      end
      default: begin
        rd_req.en = 1'b0;
      end
    endcase
  end

  // shared shift/or unit: new word = old word | (old row shifted by the value)
  assign b_eff  = bval_r ? rd_data_b : 64'd0;
  assign funnel = {b_eff, last_b_r} << bs;

  always_comb begin
    wr_req      = '0;
    wr_req.en   = wr_pend_r;
    wr_req.row  = ROW_W'(row_r);
    wr_req.word = wr_w_r;
    wr_req.data = rd_data_a | funnel[127:64];
  end

  ssdp_reach_ram u_reach (
    .clk       (clk),
    .wr        (wr_req),
    .rd        (rd_req),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      ovf_seen_r   <= 1'b0;
      target_r     <= '0;
      wr_pend_r    <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        target_r <= cfg_wr_data;
      end
      if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // pipelined write of the word read last cycle
      wr_pend_r <= 1'b0;
      if (wr_pend_r) begin
        last_b_r <= b_eff;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (32'(count_r) < MAX_ITEMS) begin
              count_r <= count_r + CNT_W'(1);
            end else begin
              ovf_seen_r <= 1'b1;
            end
            if (in_ch.is_last) begin
              n_r          <= (32'(count_r) < MAX_ITEMS) ? count_r + CNT_W'(1) : count_r;
              ovf_r        <= ovf_seen_r || (32'(count_r) >= MAX_ITEMS);
              count_r      <= '0;
              ovf_seen_r   <= 1'b0;
              j_r          <= target_r;
              row_r        <= CNT_W'(1);
              pend_valid_r <= 1'b0;
              // a target beyond the table is unreachable
              if (32'(target_r) > MAX_TARGET) begin
                fin_found_r <= 1'b0;
                state_r     <= S_FIN;
              end else begin
                state_r <= S_FETCH;
              end
            end
          end
        end
        S_FETCH: begin
          last_b_r <= '0;
          w_r      <= '0;
          state_r  <= S_ROW;
        end
        S_ROW: begin
          wr_pend_r <= 1'b1;
          wr_w_r    <= w_r;
          bval_r    <= ws_ok;
          if (32'(w_r) == NWORDS - 1) begin
            state_r <= S_DRAIN;
          end else begin
            w_r <= w_r + WORD_W'(1);
          end
        end
        S_DRAIN: begin
          if (row_r == n_r) begin
            state_r <= S_CHK;
          end else begin
            row_r   <= row_r + CNT_W'(1);
            state_r <= S_FETCH;
          end
        end
        S_CHK: begin
          state_r <= S_CHK2;
        end
        S_CHK2: begin
          row_r <= n_r;
          priority if (!rd_data_a[j_r[5:0]]) begin
            fin_found_r <= 1'b0;
            state_r     <= S_FIN;
          end else if (j_r == '0) begin
            // empty subset
            fin_found_r <= 1'b1;
            state_r     <= S_FIN;
          end else begin
            fin_found_r <= 1'b1;
            state_r     <= S_TFETCH;
          end
        end
        S_TFETCH: begin
          state_r <= S_TLOOK;
        end
        S_TLOOK: begin
          diff_r <= diff;
          if (item_q_r <= j_r) begin
            state_r <= S_TDEC;
          end else begin
            state_r <= S_TNEXT;
          end
        end
        S_TDEC: begin
          if (!rd_data_a[diff_r[5:0]]) begin
            state_r <= S_TNEXT;
          end else if (!pend_valid_r || slot_free) begin
            // item taken; the one held before it goes out as a middle result
            if (pend_valid_r) begin
              out_valid_r <= 1'b1;
              out_found_r <= 1'b1;
              out_has_r   <= 1'b1;
              out_val_r   <= pend_val_r;
              out_last_r  <= 1'b0;
              out_ovf_r   <= 1'b0;
            end
            pend_valid_r <= 1'b1;
            pend_val_r   <= item_q_r;
            j_r          <= diff_r;
            state_r      <= S_TNEXT;
          end
        end
        S_TNEXT: begin
          if ((row_r == CNT_W'(1)) || (j_r == '0)) begin
            state_r <= S_FIN;
          end else begin
            row_r   <= row_m1;
            state_r <= S_TFETCH;
          end
        end
        S_FIN: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= fin_found_r;
            out_has_r    <= pend_valid_r;
            out_val_r    <= pend_valid_r ? pend_val_r : '0;
            out_last_r   <= 1'b1;
            out_ovf_r    <= ovf_r;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = out_found_r;
  assign out_ch.has_value    = out_has_r;
  assign out_ch.chosen_value = out_val_r;
  assign out_ch.last_result  = out_last_r;
  assign out_ch.overflow     = out_ovf_r;

  // middle results always carry a member and never the overflow flag
  `SSDP_ASSERT_IMP(a_mid_result, out_ch.valid && out_ch.ready && !out_ch.last_result, out_ch.found && out_ch.has_value && !out_ch.overflow)
  // row 0 is implicit and never written
  `SSDP_ASSERT_IMP(a_no_row0_write, wr_req.en, wr_req.row != '0)
  // fill count stays within the store
  `SSDP_ASSERT_IMP(a_count_cap, 1'b1, 32'(count_r) <= MAX_ITEMS)
  // the final item of a set closes the input
  `SSDP_ASSERT_NXT(a_busy_after_last, in_ch.valid && in_ch.ready && in_ch.is_last, !in_ch.ready)
endmodule

[hw/rtl/ssdp_reach_ram.sv]
// reach table: one write port, two registered read ports
// row 0 is never stored; it reads as the set {0}; depends on ssdp_pkg
module ssdp_reach_ram (
  input  logic                clk,
  input  ssdp_pkg::reach_wr_t wr,
  input  ssdp_pkg::reach_rd_t rd,
  output ssdp_pkg::word_t     rd_data_a,
  output ssdp_pkg::word_t     rd_data_b
);
  import ssdp_pkg::*;

  word_t             mem [RAM_DEPTH];
  word_t             qa_r;
  word_t             qb_r;
  logic              zero_a_r;
  logic              zero_b_r;
  logic [WORD_W-1:0] wa_r;
  logic [WORD_W-1:0] wb_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[{wr.row, wr.word}] <= wr.data;
    end
    if (rd.en) begin
      qa_r     <= mem[{rd.row_a, rd.word_a}];
      qb_r     <= mem[{rd.row_b, rd.word_b}];
      zero_a_r <= (rd.row_a == '0);
      zero_b_r <= (rd.row_b == '0);
      wa_r     <= rd.word_a;
      wb_r     <= rd.word_b;
    end
  end

  assign rd_data_a = zero_a_r ? ((wa_r == '0) ? 64'd1 : 64'd0) : qa_r;
  assign rd_data_b = zero_b_r ? ((wb_r == '0) ? 64'd1 : 64'd0) : qb_r;
endmodule

[dv/tb_subset_sum_dp_traceback_top.sv]
// testbench for subset_sum_dp_traceback_top: directed and random number sets,
// every result checked against a reachable-sum predictor kept inside the bench
// depends on ssdp_pkg, ssdp_in_if, ssdp_out_if and the rtl of the block
module tb_subset_sum_dp_traceback_top;
  import ssdp_pkg::*;

  // longest silent stretch is a full 32-row build plus traceback
  localparam int STALL_LIMIT   = 20000;
  // pause before a target write, covers the tail of the last traceback
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 64;

  // one number of the set as it waits for the input channel
  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             is_last;
  } number_t;

  // one result item as the block should present it
  typedef struct packed {
    logic             found;
    logic             has_value;
    logic [VAL_W-1:0] chosen_value;
    logic             last_result;
    logic             overflow;
  } pick_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [VAL_W-1:0] cfg_wr_data;

  ssdp_in_if  in_ch ();
  ssdp_out_if out_ch ();

  subset_sum_dp_traceback_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  number_t          pending_numbers[$];
  pick_t            expected_picks[$];

  // predictor state: the set loaded so far, the drop flag and the target
  logic [VAL_W-1:0] set_values[$];
  logic             set_dropped;
  logic [VAL_W-1:0] target_shadow;
  logic [MAX_TARGET:0] reach_rows [0:MAX_ITEMS];

  int   send_idle_pct;
  int   recv_idle_pct;
  int   error_count  = 0;
  int   quiet_cycles = 0;
  logic in_taken     = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // loads one number into the predicted set; on the final number it builds the
  // reachable-sum rows, walks them back from the target and queues the results
  function automatic void absorb_number(logic [VAL_W-1:0] value, logic is_last);
    int               n;
    int               remain;
    logic [VAL_W-1:0] taken[$];
    pick_t            p;
    if (set_values.size() < MAX_ITEMS) begin
      set_values.push_back(value);
    end else begin
      // capacity reached: number dropped, but a final one still closes the set
      set_dropped = 1'b1;
    end
    if (!is_last) return;

    n = set_values.size();
    reach_rows[0]    = '0;
    reach_rows[0][0] = 1'b1;
    for (int i = 1; i <= n; i++) begin
      reach_rows[i] = reach_rows[i-1] | (reach_rows[i-1] << set_values[i-1]);
    end

    // backward walk: take a number when the remainder minus it was reachable
    // one row earlier; stops as soon as the remainder hits zero
    remain = int'(target_shadow);
    if (reach_rows[n][remain]) begin
      for (int i = n; i >= 1 && remain > 0; i--) begin
        if (int'(set_values[i-1]) <= remain &&
            reach_rows[i-1][remain - int'(set_values[i-1])]) begin
          taken.push_back(set_values[i-1]);
          remain = remain - int'(set_values[i-1]);
        end
      end
    end

    p = '0;
    if (!reach_rows[n][target_shadow]) begin
      // unreachable target: a single not-found item
      p.last_result = 1'b1;
      p.overflow    = set_dropped;
      expected_picks.push_back(p);
    end else if (taken.size() == 0) begin
      // zero target: found, but nothing to report
      p.found       = 1'b1;
      p.last_result = 1'b1;
      p.overflow    = set_dropped;
      expected_picks.push_back(p);
    end else begin
      foreach (taken[k]) begin
        p.found        = 1'b1;
        p.has_value    = 1'b1;
        p.chosen_value = taken[k];
        p.last_result  = (k == taken.size() - 1);
        // overflow only rides on the closing item
        p.overflow     = p.last_result ? set_dropped : 1'b0;
        expected_picks.push_back(p);
      end
    end
    set_values.delete();
    set_dropped = 1'b0;
  endfunction

  function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                      logic [VAL_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void queue_number(logic [VAL_W-1:0] value, logic is_last);
    number_t nb;
    nb.value   = value;
    nb.is_last = is_last;
    pending_numbers.push_back(nb);
  endfunction

  // random sets: mostly short, sometimes near capacity or past it; values mostly
  // under a cap chosen to make the target reachable now and then
  function automatic void queue_random_sets(int budget, int value_cap, int first_len);
    int placed;
    int len;
    placed = 0;
    while (placed < budget) begin
      if (placed == 0 && first_len > 0) begin
        len = first_len;
      end else begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 6);
          1:       len = $urandom_range(20, MAX_ITEMS);
          default: len = $urandom_range(1, 8);
        endcase
      end
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 7) == 0) begin
          queue_number(VAL_W'($urandom_range(0, MAX_TARGET)), k == len - 1);
        end else begin
          queue_number(VAL_W'($urandom_range(0, value_cap)), k == len - 1);
        end
      end
      placed += len;
    end
  endfunction

  // input side: prediction runs at the edge where the item is taken
  always @(posedge clk) begin
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_number(in_ch.item_value, in_ch.is_last);
    end
  end

  // input driver: holds an item until taken, then maybe idles, then sends the next
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (rst_n && pending_numbers.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid      <= 1'b1;
        in_ch.item_value <= pending_numbers[0].value;
        in_ch.is_last    <= pending_numbers[0].is_last;
        void'(pending_numbers.pop_front());
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side: random backpressure, then field-by-field compare
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin : result_check
    pick_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_picks.size() == 0) begin
        $error("result item with no expectation pending");
        error_count++;
      end else begin
        want = expected_picks.pop_front();
        check_field("found",        VAL_W'(want.found),       VAL_W'(out_ch.found));
        check_field("has_value",    VAL_W'(want.has_value),   VAL_W'(out_ch.has_value));
        check_field("chosen_value", want.chosen_value,        out_ch.chosen_value);
        check_field("last_result",  VAL_W'(want.last_result), VAL_W'(out_ch.last_result));
        check_field("overflow",     VAL_W'(want.overflow),    VAL_W'(out_ch.overflow));
      end
    end
  end

  // watchdog on handshake activity on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (pending_numbers.size() != 0 || in_ch.valid || expected_picks.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // target writes only with the block idle and nothing left in flight
  task automatic set_target(logic [VAL_W-1:0] t);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= t;
    target_shadow  = t;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    in_ch.valid      = 1'b0;
    in_ch.item_value = '0;
    in_ch.is_last    = 1'b0;
    out_ch.ready     = 1'b0;
    target_shadow    = '0;
    set_dropped      = 1'b0;
    send_idle_pct    = 7;
    recv_idle_pct    = 55;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero target gives an empty found item
    set_target(VAL_W'(0));
    queue_number(VAL_W'(4095), 1'b0);
    queue_number(VAL_W'(0),    1'b1);

    // directed: full-scale target, single item, two-item split, unreachable
    set_target(VAL_W'(MAX_TARGET));
    queue_number(VAL_W'(4095), 1'b1);
    queue_number(VAL_W'(2048), 1'b0);
    queue_number(VAL_W'(2047), 1'b1);
    queue_number(VAL_W'(1),    1'b0);
    queue_number(VAL_W'(2),    1'b1);

    // directed: a zero-valued number gets taken, an oversize number never is,
    // the walk stops early once the remainder is zero
    set_target(VAL_W'(10));
    queue_number(VAL_W'(0),  1'b0);
    queue_number(VAL_W'(10), 1'b0);
    queue_number(VAL_W'(0),  1'b1);
    queue_number(VAL_W'(11), 1'b0);
    queue_number(VAL_W'(3),  1'b0);
    queue_number(VAL_W'(7),  1'b1);
    queue_number(VAL_W'(4),  1'b1);

    // random, sender mostly busy and receiver stalling often
    set_target(VAL_W'($urandom_range(1, 300)));
    queue_random_sets(36, 80, 0);

    // random, sender idling often and receiver mostly ready
    set_target(VAL_W'($urandom_range(2000, MAX_TARGET)));
    send_idle_pct = 55;
    recv_idle_pct = 7;
    queue_random_sets(36, 1500, MAX_ITEMS + 2);
    set_target(VAL_W'($urandom_range(0, 63)));
    queue_random_sets(36, 20, 0);

    // random, back to back on both sides
    set_target(VAL_W'($urandom_range(64, 1024)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_sets(36, 300, MAX_ITEMS);
    set_target(VAL_W'($urandom_range(0, MAX_TARGET)));
    queue_random_sets(36, MAX_TARGET, 0);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
